// ----- rtl/core/spp_pkg.sv -----
// ----------------------------------------------------------------------------
// spp_pkg
// Shared widths, reset values and register map of the stereo ping-pong delay.
// ----------------------------------------------------------------------------
package spp_pkg;

	// Field widths
	localparam int SAMPLE_W = 24;
	localparam int GAIN_W   = 16;
	localparam int DELAY_W  = 17;

	// Default store depth in sample pairs
	localparam int STORE_DEPTH_DEF = 131072;

	// Configuration port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;
	localparam int REG_IDX_W = 3;

	// Register indexes (byte address is 4 * index)
	localparam logic [REG_IDX_W-1:0] REG_DELAY_LEFT    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DELAY_RIGHT   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_WET_GAIN      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REVERSE       = 3'd4;

	// Register reset values
	localparam logic [GAIN_W-1:0] WET_GAIN_RST      = 16'd16384;
	localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RST = 16'd16384;

endpackage

// ----- rtl/core/spp_in_if.sv -----
// ----------------------------------------------------------------------------
// spp_in_if
// Input channel: one stereo sample pair per word.
// ----------------------------------------------------------------------------
interface spp_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [spp_pkg::SAMPLE_W-1:0] in_left;
	logic signed [spp_pkg::SAMPLE_W-1:0] in_right;

	modport source (output valid, output in_left, output in_right, input ready);
	modport sink (input valid, input in_left, input in_right, output ready);
endinterface

// ----- rtl/core/spp_out_if.sv -----
// ----------------------------------------------------------------------------
// spp_out_if
// Output channel: one processed stereo sample pair per word.
// ----------------------------------------------------------------------------
interface spp_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [spp_pkg::SAMPLE_W-1:0] out_left;
	logic signed [spp_pkg::SAMPLE_W-1:0] out_right;

	modport source (output valid, output out_left, output out_right, input ready);
	modport sink (input valid, input out_left, input out_right, output ready);
endinterface

// ----- rtl/core/spp_store.sv -----
// ----------------------------------------------------------------------------
// spp_store
// Delay store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module spp_store #(
	parameter int DEPTH = spp_pkg::STORE_DEPTH_DEF,
	parameter int WIDTH = spp_pkg::SAMPLE_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read; read data is registered and holds without re
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ----- rtl/core/spp_delay_mod.sv -----
// ----------------------------------------------------------------------------
// spp_delay_mod
// Reduces both tap delays modulo the store depth by reciprocal multiplication.
// ----------------------------------------------------------------------------
// The quotient estimate floor(d * floor(2^17 / DEPTH) / 2^17) is either the
// true quotient or one below it, so one compare and subtract finishes the
// remainder. The three steps are registered in turn, and busy covers all three.
// ----------------------------------------------------------------------------
module spp_delay_mod #(
	parameter int DEPTH = spp_pkg::STORE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [spp_pkg::DELAY_W-1:0]  raw_left,
	input  logic [spp_pkg::DELAY_W-1:0]  raw_right,
	output logic [$clog2(DEPTH)-1:0]     red_left,
	output logic [$clog2(DEPTH)-1:0]     red_right,
	output logic                         busy
);

	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = spp_pkg::DELAY_W;
	localparam int RCW   = DW + 1;
	localparam int PW    = DW + RCW;
	localparam int MW    = DW + AW + 1;
	localparam int RECIP = (1 << DW) / DEPTH;

	typedef enum logic [3:0] {
		RED_IDLE = 4'b0001,
		RED_QUOT = 4'b0010,
		RED_PART = 4'b0100,
		RED_FOLD = 4'b1000
	} red_state_t;

	red_state_t    state_q;
	logic [DW-1:0] dly_l_q;
	logic [DW-1:0] dly_r_q;
	logic [DW-1:0] quo_l_q;
	logic [DW-1:0] quo_r_q;
	logic [AW:0]   part_l_q;
	logic [AW:0]   part_r_q;
	logic [AW-1:0] red_l_q;
	logic [AW-1:0] red_r_q;
	logic [PW-1:0] prod_l;
	logic [PW-1:0] prod_r;
	logic [MW-1:0] diff_l;
	logic [MW-1:0] diff_r;
	logic [AW-1:0] fold_l;
	logic [AW-1:0] fold_r;

	// Quotient estimate, partial remainder below twice the depth, final fold
	always_comb begin
		prod_l = PW'(dly_l_q) * PW'(RECIP);
		prod_r = PW'(dly_r_q) * PW'(RECIP);
		diff_l = MW'(dly_l_q) - MW'(quo_l_q) * MW'(DEPTH);
		diff_r = MW'(dly_r_q) - MW'(quo_r_q) * MW'(DEPTH);
		fold_l = (part_l_q >= (AW + 1)'(DEPTH)) ?
			AW'(part_l_q - (AW + 1)'(DEPTH)) : part_l_q[AW-1:0];
		fold_r = (part_r_q >= (AW + 1)'(DEPTH)) ?
			AW'(part_r_q - (AW + 1)'(DEPTH)) : part_r_q[AW-1:0];
	end

	// Load on a delay write, then step through the three stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= RED_IDLE;
			dly_l_q  <= '0;
			dly_r_q  <= '0;
			quo_l_q  <= '0;
			quo_r_q  <= '0;
			part_l_q <= '0;
			part_r_q <= '0;
			red_l_q  <= '0;
			red_r_q  <= '0;
		end else if (start) begin
			dly_l_q <= raw_left;
			dly_r_q <= raw_right;
			state_q <= RED_QUOT;
		end else begin
			case (state_q)
				RED_IDLE: begin
				end
				RED_QUOT: begin
					quo_l_q <= prod_l[DW +: DW];
					quo_r_q <= prod_r[DW +: DW];
					state_q <= RED_PART;
				end
				RED_PART: begin
					part_l_q <= diff_l[AW:0];
					part_r_q <= diff_r[AW:0];
					state_q  <= RED_FOLD;
				end
				RED_FOLD: begin
					red_l_q <= fold_l;
					red_r_q <= fold_r;
					state_q <= RED_IDLE;
				end
				default: begin
					state_q <= RED_IDLE;
				end
			endcase
		end
	end

	assign red_left  = red_l_q;
	assign red_right = red_r_q;
	assign busy      = (state_q != RED_IDLE);

endmodule

// ----- rtl/core/spp_mix.sv -----
// ----------------------------------------------------------------------------
// spp_mix
// Gain, rounding and saturation pipeline with store write-back and output
// register.
// ----------------------------------------------------------------------------
module spp_mix #(
	parameter int DEPTH = spp_pkg::STORE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Accepted word
	input  logic                                accept,
	input  logic signed [spp_pkg::SAMPLE_W-1:0] in_left,
	input  logic signed [spp_pkg::SAMPLE_W-1:0] in_right,
	input  logic [$clog2(DEPTH)-1:0]            wp,
	input  logic                                ok_left,
	input  logic                                ok_right,
	// Tap addresses of the word on offer, for the interlock
	input  logic [$clog2(DEPTH)-1:0]            tap_left,
	input  logic [$clog2(DEPTH)-1:0]            tap_right,
	output logic                                hazard,
	output logic                                en,
	// Store read data
	input  logic [spp_pkg::SAMPLE_W-1:0]        left_at_l,
	input  logic [spp_pkg::SAMPLE_W-1:0]        left_at_r,
	input  logic [spp_pkg::SAMPLE_W-1:0]        right_at_l,
	input  logic [spp_pkg::SAMPLE_W-1:0]        right_at_r,
	// Settings
	input  logic [spp_pkg::GAIN_W-1:0]          wet_gain,
	input  logic [spp_pkg::GAIN_W-1:0]          feedback_gain,
	input  logic                                reverse,
	// Store write
	output logic                                we,
	output logic [$clog2(DEPTH)-1:0]            waddr,
	output logic [spp_pkg::SAMPLE_W-1:0]        wdata_left,
	output logic [spp_pkg::SAMPLE_W-1:0]        wdata_right,
	// Result
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [spp_pkg::SAMPLE_W-1:0] out_left,
	output logic signed [spp_pkg::SAMPLE_W-1:0] out_right
);

	localparam int AW = $clog2(DEPTH);
	localparam int SW = spp_pkg::SAMPLE_W;
	localparam int GW = spp_pkg::GAIN_W;
	localparam int PW = SW + GW + 1;
	localparam int RW = PW + 1;
	localparam int QW = RW - 15;
	localparam int TW = QW + 1;

	// Round the product half up, add the input, clamp to the sample range
	function automatic logic signed [SW-1:0] finish(
		input logic signed [SW-1:0] smp,
		input logic signed [PW-1:0] prod
	);
		logic signed [RW-1:0] biased;
		logic signed [QW-1:0] scaled;
		logic signed [TW-1:0] sum;
		logic signed [TW-1:0] hi;
		logic signed [TW-1:0] lo;
		biased = RW'(prod) + RW'(16384);
		scaled = biased[RW-1:15];
		sum    = TW'(smp) + TW'(scaled);
		hi     = TW'((1 << (SW - 1)) - 1);
		lo     = -TW'(1 << (SW - 1));
		if (sum > hi) begin
			finish = hi[SW-1:0];
		end else if (sum < lo) begin
			finish = lo[SW-1:0];
		end else begin
			finish = sum[SW-1:0];
		end
	endfunction

	logic                 v_s1;
	logic signed [SW-1:0] in_l_s1;
	logic signed [SW-1:0] in_r_s1;
	logic [AW-1:0]        wp_s1;
	logic                 ok_l_s1;
	logic                 ok_r_s1;

	logic                 v_s2;
	logic signed [SW-1:0] in_l_s2;
	logic signed [SW-1:0] in_r_s2;
	logic [AW-1:0]        wp_s2;
	logic signed [PW-1:0] wet_l_s2;
	logic signed [PW-1:0] wet_r_s2;
	logic signed [PW-1:0] fb_l_s2;
	logic signed [PW-1:0] fb_r_s2;

	logic                 out_valid_q;
	logic signed [SW-1:0] out_left_q;
	logic signed [SW-1:0] out_right_q;

	logic signed [SW-1:0] l_at_l;
	logic signed [SW-1:0] r_at_r;
	logic signed [SW-1:0] tap_l;
	logic signed [SW-1:0] tap_r;
	logic signed [GW:0]   wet_s;
	logic signed [GW:0]   fb_s;
	logic signed [SW-1:0] res_l;
	logic signed [SW-1:0] res_r;

	// Advance the whole pipe unless a finished word is held at the output
	assign en = !out_valid_q || out_ready;

	// Hold off a word whose taps hit a write still in flight
	assign hazard = (v_s1 && (wp_s1 == tap_left || wp_s1 == tap_right)) ||
		(v_s2 && (wp_s2 == tap_left || wp_s2 == tap_right));

	// Select taps; entries never written read as zero
	always_comb begin
		l_at_l = ok_l_s1 ? signed'(left_at_l) : '0;
		r_at_r = ok_r_s1 ? signed'(right_at_r) : '0;
		if (reverse) begin
			tap_l = ok_l_s1 ? signed'(right_at_l) : '0;
			tap_r = ok_r_s1 ? signed'(left_at_r) : '0;
		end else begin
			tap_l = l_at_l;
			tap_r = r_at_r;
		end
		wet_s = signed'({1'b0, wet_gain});
		fb_s  = signed'({1'b0, feedback_gain});
	end

	// Stage 1: capture the accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_l_s1 <= in_left;
			in_r_s1 <= in_right;
			wp_s1   <= wp;
			ok_l_s1 <= ok_left;
			ok_r_s1 <= ok_right;
		end
	end

	// Stage 2: register the four gain products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_l_s2  <= in_l_s1;
			in_r_s2  <= in_r_s1;
			wp_s2    <= wp_s1;
			wet_l_s2 <= tap_l * wet_s;
			wet_r_s2 <= tap_r * wet_s;
			fb_l_s2  <= r_at_r * fb_s;
			fb_r_s2  <= l_at_l * fb_s;
		end
	end

	// Round, add and clamp; write back to the stores
	assign res_l       = finish(in_l_s2, wet_l_s2);
	assign res_r       = finish(in_r_s2, wet_r_s2);
	assign we          = en && v_s2;
	assign waddr       = wp_s2;
	assign wdata_left  = finish(in_l_s2, fb_l_s2);
	assign wdata_right = finish(in_r_s2, fb_r_s2);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s2) begin
			out_left_q  <= res_l;
			out_right_q <= res_r;
		end
	end

	assign out_valid = out_valid_q;
	assign out_left  = out_left_q;
	assign out_right = out_right_q;

endmodule

// ----- rtl/core/stereo_ping_pong_delay_unit.sv -----
// ----------------------------------------------------------------------------
// stereo_ping_pong_delay_unit
// Stereo ping-pong delay with cross-fed circular stores.
// ----------------------------------------------------------------------------
// Words arrive on audio_in (one left/right sample pair, signed Q1.23) and
// leave on audio_out, one result word per input word, in order. Settings are
// written over the APB port: tap delays in samples, wet and feedback gains
// (unsigned Q1.15) and the channel reverse bit; write them while idle.
// A result word moves through stage 1, stage 2 and the output register once its
// input word is accepted. One word is taken per cycle unless the output stalls,
// a hazard holds it or the reducer is busy: each store has two read ports and
// one write port, so both taps and the write-back of a word fit in a single
// pass. A word whose tap address equals a store entry still being written by
// one of the two words ahead of it waits until that write lands; this happens
// when a tap lies one or two entries behind the write position. After a delay
// write the reducer folds both delays modulo the depth, and no word is taken
// while it is busy. Reset clears delays, reverse bit, write position and fill
// mark and loads the gain reset values; unwritten store entries read as zero,
// so no clearing pass is run. When audio_out stalls, the result stays in the
// output register, the pipeline holds and audio_in.ready stays low until taken.
// ----------------------------------------------------------------------------
module stereo_ping_pong_delay_unit #(
	parameter int STORE_DEPTH = spp_pkg::STORE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	spp_in_if.sink                        audio_in,
	spp_out_if.source                     audio_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [spp_pkg::APB_AW-1:0]    paddr,
	input  logic [spp_pkg::APB_DW-1:0]    pwdata,
	output logic [spp_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int SW = spp_pkg::SAMPLE_W;
	localparam int DW = spp_pkg::DELAY_W;
	localparam int GW = spp_pkg::GAIN_W;

	logic [DW-1:0] delay_left_q;
	logic [DW-1:0] delay_right_q;
	logic [GW-1:0] wet_gain_q;
	logic [GW-1:0] feedback_gain_q;
	logic          reverse_q;

	logic [spp_pkg::REG_IDX_W-1:0] reg_idx;
	logic          cfg_wr;
	logic          delay_wr;
	logic [DW-1:0] raw_left;
	logic [DW-1:0] raw_right;
	logic [AW-1:0] red_left;
	logic [AW-1:0] red_right;
	logic          busy;

	logic [AW-1:0] wp_q;
	logic          filled_q;
	logic [AW:0]   diff_l;
	logic [AW:0]   diff_r;
	logic [AW-1:0] tap_left;
	logic [AW-1:0] tap_right;
	logic          ok_left;
	logic          ok_right;
	logic          hazard;
	logic          en;
	logic          accept;

	logic          we;
	logic [AW-1:0] waddr;
	logic [SW-1:0] wdata_left;
	logic [SW-1:0] wdata_right;
	logic [SW-1:0] left_at_l;
	logic [SW-1:0] left_at_r;
	logic [SW-1:0] right_at_l;
	logic [SW-1:0] right_at_r;

	// Configuration port
	assign pready   = 1'b1;
	assign reg_idx  = paddr[spp_pkg::APB_AW-1:2];
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign delay_wr = cfg_wr &&
		(reg_idx == spp_pkg::REG_DELAY_LEFT || reg_idx == spp_pkg::REG_DELAY_RIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_left_q    <= '0;
			delay_right_q   <= '0;
			wet_gain_q      <= spp_pkg::WET_GAIN_RST;
			feedback_gain_q <= spp_pkg::FEEDBACK_GAIN_RST;
			reverse_q       <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				spp_pkg::REG_DELAY_LEFT: begin
					delay_left_q <= pwdata[DW-1:0];
				end
				spp_pkg::REG_DELAY_RIGHT: begin
					delay_right_q <= pwdata[DW-1:0];
				end
				spp_pkg::REG_WET_GAIN: begin
					wet_gain_q <= pwdata[GW-1:0];
				end
				spp_pkg::REG_FEEDBACK_GAIN: begin
					feedback_gain_q <= pwdata[GW-1:0];
				end
				spp_pkg::REG_REVERSE: begin
					reverse_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			spp_pkg::REG_DELAY_LEFT:    prdata = spp_pkg::APB_DW'(delay_left_q);
			spp_pkg::REG_DELAY_RIGHT:   prdata = spp_pkg::APB_DW'(delay_right_q);
			spp_pkg::REG_WET_GAIN:      prdata = spp_pkg::APB_DW'(wet_gain_q);
			spp_pkg::REG_FEEDBACK_GAIN: prdata = spp_pkg::APB_DW'(feedback_gain_q);
			spp_pkg::REG_REVERSE:       prdata = spp_pkg::APB_DW'(reverse_q);
			default:                    prdata = '0;
		endcase
	end

	// Fold delays modulo the depth, using the value being written
	assign raw_left  = (reg_idx == spp_pkg::REG_DELAY_LEFT) ? pwdata[DW-1:0] : delay_left_q;
	assign raw_right = (reg_idx == spp_pkg::REG_DELAY_RIGHT) ? pwdata[DW-1:0] : delay_right_q;

	spp_delay_mod #(
		.DEPTH (STORE_DEPTH)
	) u_delay_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (delay_wr),
		.raw_left  (raw_left),
		.raw_right (raw_right),
		.red_left  (red_left),
		.red_right (red_right),
		.busy      (busy)
	);

	// Tap addresses behind the write position, wrapped into the store
	always_comb begin
		diff_l = {1'b0, wp_q} - {1'b0, red_left};
		diff_r = {1'b0, wp_q} - {1'b0, red_right};
		tap_left  = diff_l[AW] ? AW'(diff_l + (AW + 1)'(STORE_DEPTH)) : diff_l[AW-1:0];
		tap_right = diff_r[AW] ? AW'(diff_r + (AW + 1)'(STORE_DEPTH)) : diff_r[AW-1:0];
		ok_left   = filled_q || (tap_left < wp_q);
		ok_right  = filled_q || (tap_right < wp_q);
	end

	// Input handshake
	assign audio_in.ready = en && !busy && !hazard;
	assign accept         = audio_in.valid && audio_in.ready;

	// Advance the write position; mark the stores full after the first wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			filled_q <= 1'b0;
		end else if (accept) begin
			if (wp_q == AW'(STORE_DEPTH - 1)) begin
				wp_q     <= '0;
				filled_q <= 1'b1;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

	// Delay stores
	spp_store #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (SW)
	) u_left_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata_left),
		.re      (accept),
		.raddr_a (tap_left),
		.raddr_b (tap_right),
		.rdata_a (left_at_l),
		.rdata_b (left_at_r)
	);

	spp_store #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (SW)
	) u_right_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata_right),
		.re      (accept),
		.raddr_a (tap_left),
		.raddr_b (tap_right),
		.rdata_a (right_at_l),
		.rdata_b (right_at_r)
	);

	// Arithmetic pipeline and output register
	spp_mix #(
		.DEPTH (STORE_DEPTH)
	) u_mix (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_left       (audio_in.in_left),
		.in_right      (audio_in.in_right),
		.wp            (wp_q),
		.ok_left       (ok_left),
		.ok_right      (ok_right),
		.tap_left      (tap_left),
		.tap_right     (tap_right),
		.hazard        (hazard),
		.en            (en),
		.left_at_l     (left_at_l),
		.left_at_r     (left_at_r),
		.right_at_l    (right_at_l),
		.right_at_r    (right_at_r),
		.wet_gain      (wet_gain_q),
		.feedback_gain (feedback_gain_q),
		.reverse       (reverse_q),
		.we            (we),
		.waddr         (waddr),
		.wdata_left    (wdata_left),
		.wdata_right   (wdata_right),
		.out_valid     (audio_out.valid),
		.out_ready     (audio_out.ready),
		.out_left      (audio_out.out_left),
		.out_right     (audio_out.out_right)
	);

	// A tap is never read at the edge where its entry is being written
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !(we && (waddr == tap_left || waddr == tap_right)))
		else $error("tap read collides with store write");

	// No word is taken while a delay is being folded
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !busy)
		else $error("word accepted during delay reduction");

	// Folded delays stay inside the store once the reducer is done
	a_delay_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> ((AW + 1)'(red_left) < (AW + 1)'(STORE_DEPTH) &&
			(AW + 1)'(red_right) < (AW + 1)'(STORE_DEPTH)))
		else $error("folded delay beyond store depth");

	// Each accepted word moves the write position
	a_wp_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> wp_q != $past(wp_q))
		else $error("write position did not advance");

endmodule
